// ===== rtl/i2cbb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbb_pkg: shared types and constants of the bit-bang I2C master
// Transaction structs, command codes, sequencer phases and timing helpers.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Command codes carried in the mode field
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // Timing register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF  = 2'd2;

  localparam logic [CFG_W-1:0] HOLD_RST  = 8'd2;
  localparam logic [CFG_W-1:0] SETUP_RST = 8'd8;
  localparam logic [CFG_W-1:0] HALF_RST  = 8'd10;

  typedef enum logic [4:0] {
    PH_IDLE        = 5'd0,
    PH_S_SDA_LOW   = 5'd1,
    PH_S_SCL_LOW   = 5'd2,
    PH_P_SDA_LOW   = 5'd3,
    PH_P_SCL_HIGH  = 5'd4,
    PH_P_SDA_HIGH  = 5'd5,
    PH_W_DATA      = 5'd6,
    PH_W_SCL_HIGH  = 5'd7,
    PH_W_SCL_LOW   = 5'd8,
    PH_W_ACK_HIGH  = 5'd9,
    PH_W_ACK_LOW   = 5'd10,
    PH_R_SCL_HIGH  = 5'd11,
    PH_R_SAMPLE    = 5'd12,
    PH_R_SCL_LOW   = 5'd13,
    PH_R_ACK_DRIVE = 5'd14,
    PH_R_ACK_HIGH  = 5'd15,
    PH_R_ACK_LOW   = 5'd16
  } phase_e;

  typedef struct packed {
    logic [2:0]           mode;
    logic [BYTE_BITS-1:0] tx_byte;
    logic                 last_byte;
    logic                 sda_in;
  } tick_in_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_enable;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 rx_valid;
    logic [2:0]           rx_slot;
    logic                 cmd_dropped;
  } tick_out_t;

  // A zero timing register behaves as a one-tick wait
  function automatic logic [CFG_W-1:0] wait_len(input logic [CFG_W-1:0] reg_val);
    wait_len = (reg_val == '0) ? CFG_W'(1) : reg_val;
  endfunction

endpackage

// ===== rtl/i2c_bitbang_master.sv =====
// ----------------------------------------------------------------------------
// i2c_bitbang_master: tick-driven I2C master sequencer
// Drives SCL/SDA through start, stop, byte write and byte read sequences.
// ----------------------------------------------------------------------------
// Every input transaction is one timing tick of the bus sequencer and yields
// exactly one output transaction that shows the line drive after that tick,
// plus done, busy, received-byte and dropped-command status. A tick is taken
// on each handshake: the sequencer state and the result register update
// together on the accepting edge, and a new tick is accepted while the last
// result waits as long as the output side takes it in the same cycle, so the
// stall-free rate is one transaction per clock, set by the single result
// register. Commands (start, stop, write, read) begin only while idle; one
// that arrives while an operation runs, including its final tick, is ignored
// and flagged with cmd_dropped. Mode codes 5 to 7 act as plain ticks. The
// hold, setup and half timing registers give phase lengths in ticks (zero
// counts as one) and are read when each wait begins; write them only while
// the block is idle. Write sends MSB first and clocks an ACK with SDA released
// without sampling it; read samples SDA during SCL high and answers ACK or,
// for a byte marked last, NACK. Received bytes carry a ring slot that counts
// 0 to RX_SLOTS-1 and wraps.
// ----------------------------------------------------------------------------
module i2c_bitbang_master #(
  parameter int unsigned RX_SLOTS = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [i2cbb_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [i2cbb_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  i2cbb_pkg::tick_in_t                  in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output i2cbb_pkg::tick_out_t                 out_o
);
  import i2cbb_pkg::*;

  localparam int unsigned RING_W = (RX_SLOTS > 1) ? $clog2(RX_SLOTS) : 1;

  // Timing registers
  logic [CFG_W-1:0] hold_q, setup_q, half_q;

  // Sequencer state
  phase_e               phase_q, phase_d;
  logic [CFG_W-1:0]     tick_q, tick_d;
  logic [3:0]           bit_q, bit_d;
  logic [BYTE_BITS-1:0] shift_q, shift_d;
  logic                 nack_q, nack_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 oe_q, oe_d;
  logic [RING_W-1:0]    ring_q, ring_d;

  // Result register
  tick_out_t            res_q, res_d;
  logic                 out_valid_q;

  logic                 accept;
  logic                 busy;
  logic                 is_cmd;
  logic [CFG_W-1:0]     tick_dec;
  logic                 fire;
  logic [3:0]           bit_inc;
  logic                 more_bits;
  logic [RING_W+2:0]    ring_ext;

  // Advance whenever the result register is empty or is drained this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign busy      = (phase_q != PH_IDLE);
  assign is_cmd    = (in_i.mode == MODE_START) || (in_i.mode == MODE_STOP) ||
                     (in_i.mode == MODE_WRITE) || (in_i.mode == MODE_READ);
  assign tick_dec  = (tick_q != '0) ? tick_q - CFG_W'(1) : '0;
  assign fire      = busy && (tick_dec == '0);
  assign bit_inc   = bit_q + 4'd1;
  assign more_bits = (bit_inc < 4'(BYTE_BITS));
  assign ring_ext  = {3'b000, ring_q};

  // --------------------------------------------------------------------------
  // Next phase and wait counter
  // --------------------------------------------------------------------------
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    if (accept) begin
      if (busy) begin
        tick_d = tick_dec;
        if (fire) begin
          case (phase_q)
            PH_S_SDA_LOW: begin
              phase_d = PH_S_SCL_LOW;
              tick_d  = wait_len(half_q);
            end
            PH_P_SDA_LOW: begin
              phase_d = PH_P_SCL_HIGH;
              tick_d  = wait_len(setup_q);
            end
            PH_P_SCL_HIGH: begin
              phase_d = PH_P_SDA_HIGH;
              tick_d  = wait_len(hold_q);
            end
            PH_W_DATA: begin
              phase_d = PH_W_SCL_HIGH;
              tick_d  = wait_len(setup_q);
            end
            PH_W_SCL_HIGH: begin
              phase_d = PH_W_SCL_LOW;
              tick_d  = wait_len(half_q);
            end
            PH_W_SCL_LOW: begin
              if (more_bits) begin
                phase_d = PH_W_DATA;
                tick_d  = wait_len(hold_q);
              end else begin
                phase_d = PH_W_ACK_HIGH;
                tick_d  = wait_len(half_q);
              end
            end
            PH_W_ACK_HIGH: begin
              phase_d = PH_W_ACK_LOW;
              tick_d  = wait_len(half_q);
            end
            PH_R_SCL_HIGH: begin
              phase_d = PH_R_SAMPLE;
              tick_d  = wait_len(hold_q);
            end
            PH_R_SAMPLE: begin
              phase_d = PH_R_SCL_LOW;
              tick_d  = wait_len(setup_q);
            end
            PH_R_SCL_LOW: begin
              if (more_bits) begin
                phase_d = PH_R_SCL_HIGH;
                tick_d  = wait_len(half_q);
              end else begin
                phase_d = PH_R_ACK_DRIVE;
                tick_d  = wait_len(hold_q);
              end
            end
            PH_R_ACK_DRIVE: begin
              phase_d = PH_R_ACK_HIGH;
              tick_d  = wait_len(setup_q);
            end
            PH_R_ACK_HIGH: begin
              phase_d = PH_R_ACK_LOW;
              tick_d  = wait_len(half_q);
            end
            default: begin
              // Last step of every operation, and any stray code: go idle
              phase_d = PH_IDLE;
              tick_d  = '0;
            end
          endcase
        end
      end else if (is_cmd) begin
        case (in_i.mode)
          MODE_START: begin
            phase_d = PH_S_SDA_LOW;
            tick_d  = wait_len(half_q);
          end
          MODE_STOP: begin
            phase_d = PH_P_SDA_LOW;
            tick_d  = wait_len(hold_q);
          end
          MODE_WRITE: begin
            phase_d = PH_W_DATA;
            tick_d  = wait_len(hold_q);
          end
          default: begin
            phase_d = PH_R_SCL_HIGH;
            tick_d  = wait_len(half_q);
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line drive, data path and result
  // --------------------------------------------------------------------------
  always_comb begin
    scl_d   = scl_q;
    sda_d   = sda_q;
    oe_d    = oe_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    nack_d  = nack_q;
    ring_d  = ring_q;
    res_d   = '0;
    if (accept) begin
      if (busy) begin
        res_d.cmd_dropped = is_cmd;
        if (fire) begin
          case (phase_q)
            PH_S_SDA_LOW: sda_d = 1'b0;
            PH_S_SCL_LOW: begin
              scl_d          = 1'b0;
              res_d.done_res = 1'b1;
            end
            PH_P_SDA_LOW: begin
              oe_d  = 1'b1;
              sda_d = 1'b0;
            end
            PH_P_SCL_HIGH: scl_d = 1'b1;
            PH_P_SDA_HIGH: begin
              sda_d          = 1'b1;
              res_d.done_res = 1'b1;
            end
            PH_W_DATA: begin
              sda_d   = shift_q[BYTE_BITS-1];
              shift_d = {shift_q[BYTE_BITS-2:0], 1'b0};
            end
            PH_W_SCL_HIGH: scl_d = 1'b1;
            PH_W_SCL_LOW: begin
              scl_d = 1'b0;
              bit_d = bit_inc;
              if (!more_bits) begin
                oe_d = 1'b0;
              end
            end
            PH_W_ACK_HIGH: scl_d = 1'b1;
            PH_W_ACK_LOW: begin
              scl_d          = 1'b0;
              res_d.done_res = 1'b1;
            end
            PH_R_SCL_HIGH: scl_d = 1'b1;
            PH_R_SAMPLE: shift_d = {shift_q[BYTE_BITS-2:0], in_i.sda_in};
            PH_R_SCL_LOW: begin
              scl_d = 1'b0;
              bit_d = bit_inc;
            end
            PH_R_ACK_DRIVE: begin
              oe_d  = 1'b1;
              sda_d = nack_q;
            end
            PH_R_ACK_HIGH: scl_d = 1'b1;
            PH_R_ACK_LOW: begin
              scl_d          = 1'b0;
              res_d.rx_byte  = shift_q;
              res_d.rx_valid = 1'b1;
              res_d.rx_slot  = ring_ext[2:0];
              res_d.done_res = 1'b1;
              ring_d = (ring_q == RING_W'(RX_SLOTS - 1)) ? '0 : ring_q + RING_W'(1);
            end
            default: ;
          endcase
        end
      end else if (is_cmd) begin
        bit_d = '0;
        case (in_i.mode)
          MODE_START: begin
            scl_d = 1'b1;
            sda_d = 1'b1;
            oe_d  = 1'b1;
          end
          MODE_STOP: ;
          MODE_WRITE: begin
            oe_d    = 1'b1;
            shift_d = in_i.tx_byte;
          end
          default: begin
            oe_d    = 1'b0;
            shift_d = '0;
            nack_d  = in_i.last_byte;
          end
        endcase
      end
    end
    res_d.scl_level  = scl_d;
    res_d.sda_level  = sda_d;
    res_d.sda_enable = oe_d;
    res_d.busy_res   = (phase_d != PH_IDLE);
  end

  // Timing registers: hold the reset timing until written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= HOLD_RST;
      setup_q <= SETUP_RST;
      half_q  <= HALF_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_HOLD:  hold_q  <= cfg_wdata_i;
        CFG_SETUP: setup_q <= cfg_wdata_i;
        CFG_HALF:  half_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      nack_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      oe_q    <= 1'b0;
      ring_q  <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      nack_q  <= nack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      oe_q    <= oe_d;
      ring_q  <= ring_d;
    end
  end

  // Result register: load on accept, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;

endmodule

// ===== test/tb_i2c_bitbang_master.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_bitbang_master: self-checking bench for the tick-driven I2C master
// Drives tick transactions through the valid/ready ports, predicts the line
// drive and status of every tick, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_i2c_bitbang_master;
  import i2cbb_pkg::*;

  localparam int unsigned RX_SLOTS        = 6;
  localparam logic [2:0]  MODE_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  MODE_RSVD_LAST  = 3'd7;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          DRAIN_CYCLES    = 4;
  localparam int          STALL_LIMIT     = 2000;

  // Per-tick predictor of the bus sequencer plus the queue of line states
  // it expects the block to report, oldest first.
  class i2c_line_scoreboard;
    logic [CFG_W-1:0]     hold_r, setup_r, half_r;
    phase_e               phase;
    logic [CFG_W-1:0]     wait_cnt;
    logic [3:0]           bit_cnt;
    logic [BYTE_BITS-1:0] shifter;
    logic                 nack, scl, sda, sda_oe;
    int unsigned          slot;
    tick_out_t            expected_lines[$];
    int                   errors, ticks, dropped, bytes_in, wraps;
    int                   begun[8];

    function new();
      hold_r   = HOLD_RST;
      setup_r  = SETUP_RST;
      half_r   = HALF_RST;
      phase    = PH_IDLE;
      wait_cnt = '0;
      bit_cnt  = '0;
      shifter  = '0;
      nack     = 1'b0;
      scl      = 1'b1;
      sda      = 1'b1;
      sda_oe   = 1'b0;
      slot     = 0;
    endfunction

    function void set_timing(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_HOLD:  hold_r = v;
        CFG_SETUP: setup_r = v;
        CFG_HALF:  half_r = v;
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    // True when the next tick ends the running operation
    function bit final_tick();
      return wait_cnt <= 1 &&
             phase inside {PH_S_SCL_LOW, PH_P_SDA_HIGH, PH_W_ACK_LOW, PH_R_ACK_LOW};
    endfunction

    function int outstanding();
      return expected_lines.size();
    endfunction

    // Load a wait; a zero register still waits one tick
    function void enter(phase_e p, logic [CFG_W-1:0] r);
      phase    = p;
      wait_cnt = (r == '0) ? CFG_W'(1) : r;
    endfunction

    function void close_op();
      phase    = PH_IDLE;
      wait_cnt = '0;
    endfunction

    function void note_tick(tick_in_t t);
      tick_out_t e;
      bit        cmd;
      e   = '0;
      cmd = (t.mode >= MODE_START) && (t.mode <= MODE_READ);
      ticks++;
      if (phase != PH_IDLE) begin
        if (cmd) begin
          e.cmd_dropped = 1'b1;
          dropped++;
        end
        if (wait_cnt != 0) wait_cnt--;
        if (wait_cnt == 0) begin
          case (phase)
            PH_S_SDA_LOW: begin
              sda = 1'b0;
              enter(PH_S_SCL_LOW, half_r);
            end
            PH_S_SCL_LOW: begin
              scl = 1'b0;
              close_op();
              e.done_res = 1'b1;
            end
            PH_P_SDA_LOW: begin
              sda_oe = 1'b1;
              sda    = 1'b0;
              enter(PH_P_SCL_HIGH, setup_r);
            end
            PH_P_SCL_HIGH: begin
              scl = 1'b1;
              enter(PH_P_SDA_HIGH, hold_r);
            end
            PH_P_SDA_HIGH: begin
              sda = 1'b1;
              close_op();
              e.done_res = 1'b1;
            end
            PH_W_DATA: begin
              sda     = shifter[BYTE_BITS-1];
              shifter = shifter << 1;
              enter(PH_W_SCL_HIGH, setup_r);
            end
            PH_W_SCL_HIGH: begin
              scl = 1'b1;
              enter(PH_W_SCL_LOW, half_r);
            end
            PH_W_SCL_LOW: begin
              scl = 1'b0;
              bit_cnt++;
              if (bit_cnt < BYTE_BITS) begin
                enter(PH_W_DATA, hold_r);
              end else begin
                sda_oe = 1'b0;
                enter(PH_W_ACK_HIGH, half_r);
              end
            end
            PH_W_ACK_HIGH: begin
              scl = 1'b1;
              enter(PH_W_ACK_LOW, half_r);
            end
            PH_W_ACK_LOW: begin
              scl = 1'b0;
              close_op();
              e.done_res = 1'b1;
            end
            PH_R_SCL_HIGH: begin
              scl = 1'b1;
              enter(PH_R_SAMPLE, hold_r);
            end
            PH_R_SAMPLE: begin
              shifter = {shifter[BYTE_BITS-2:0], t.sda_in};
              enter(PH_R_SCL_LOW, setup_r);
            end
            PH_R_SCL_LOW: begin
              scl = 1'b0;
              bit_cnt++;
              if (bit_cnt < BYTE_BITS) enter(PH_R_SCL_HIGH, half_r);
              else enter(PH_R_ACK_DRIVE, hold_r);
            end
            PH_R_ACK_DRIVE: begin
              sda_oe = 1'b1;
              sda    = nack;
              enter(PH_R_ACK_HIGH, setup_r);
            end
            PH_R_ACK_HIGH: begin
              scl = 1'b1;
              enter(PH_R_ACK_LOW, half_r);
            end
            PH_R_ACK_LOW: begin
              scl        = 1'b0;
              e.rx_byte  = shifter;
              e.rx_valid = 1'b1;
              e.rx_slot  = 3'(slot);
              bytes_in++;
              if (slot + 1 >= RX_SLOTS) begin
                slot = 0;
                wraps++;
              end else begin
                slot++;
              end
              close_op();
              e.done_res = 1'b1;
            end
            default: close_op();
          endcase
        end
      end else if (cmd) begin
        bit_cnt = '0;
        begun[t.mode]++;
        case (t.mode)
          MODE_START: begin
            scl    = 1'b1;
            sda    = 1'b1;
            sda_oe = 1'b1;
            enter(PH_S_SDA_LOW, half_r);
          end
          MODE_STOP: enter(PH_P_SDA_LOW, hold_r);
          MODE_WRITE: begin
            sda_oe  = 1'b1;
            shifter = t.tx_byte;
            enter(PH_W_DATA, hold_r);
          end
          default: begin
            sda_oe  = 1'b0;
            shifter = '0;
            nack    = t.last_byte;
            enter(PH_R_SCL_HIGH, half_r);
          end
        endcase
      end
      e.scl_level  = scl;
      e.sda_level  = sda;
      e.sda_enable = sda_oe;
      e.busy_res   = (phase != PH_IDLE);
      expected_lines.push_back(e);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        if (errors < 50) $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_lines(tick_out_t got);
      tick_out_t want;
      if (expected_lines.size() == 0) begin
        $error("result transaction with no tick waiting for it");
        errors++;
        return;
      end
      want = expected_lines.pop_front();
      compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
      compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
      compare_field("sda_enable", 8'(want.sda_enable), 8'(got.sda_enable));
      compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
      compare_field("rx_byte", want.rx_byte, got.rx_byte);
      compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
      compare_field("rx_slot", 8'(want.rx_slot), 8'(got.rx_slot));
      compare_field("cmd_dropped", 8'(want.cmd_dropped), 8'(got.cmd_dropped));
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i  = CFG_HOLD;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  tick_in_t             in_i        = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  tick_out_t            out_o;

  i2c_line_scoreboard sb;
  bit send_calm     = 1'b0;
  bit recv_calm     = 1'b0;
  bit hold_off_req  = 1'b0;
  int quiet_cycles  = 0;
  int timing_sets   = 0;

  i2c_bitbang_master #(
    .RX_SLOTS(RX_SLOTS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly back-to-back, some short gaps, a rare long one
  function automatic int pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // Plain timing tick with random don't-care fields; sda_sel 2 picks SDA at
  // random, otherwise it gives the level to sample.
  function automatic tick_in_t filler(int sda_sel);
    tick_in_t t;
    t.mode      = MODE_TICK;
    t.tx_byte   = 8'($urandom);
    t.last_byte = 1'($urandom);
    t.sda_in    = (sda_sel == 2) ? 1'($urandom) : 1'(sda_sel);
    return t;
  endfunction

  // Offer one tick, hold it until taken, log it, then maybe idle. Valid is
  // left high after a zero gap so the next call reuses it without a glitch.
  task automatic send_tick(input tick_in_t t);
    int gap;
    in_valid_i <= 1'b1;
    in_i       <= t;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(t);
    gap = send_calm ? 0 : pick_delay();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Run the sequencer to idle, drop valid and wait for every result
  task automatic settle();
    while (sb.busy()) send_tick(filler(2));
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timing(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] s,
                              input logic [CFG_W-1:0] f);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_HOLD;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_SETUP;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_HALF;
    cfg_wdata_i <= f;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_timing(CFG_HOLD, h);
    sb.set_timing(CFG_SETUP, s);
    sb.set_timing(CFG_HALF, f);
    timing_sets++;
  endtask

  // Issue one command from idle and tick it through to completion
  task automatic run_op(input logic [2:0] mode, input logic [7:0] tx, input logic last,
                        input int sda_sel);
    tick_in_t t;
    t           = filler(sda_sel);
    t.mode      = mode;
    t.tx_byte   = tx;
    t.last_byte = last;
    send_tick(t);
    while (sb.busy()) send_tick(filler(sda_sel));
  endtask

  // Random traffic: mostly framed transfers (start, address, data bytes,
  // stop) with commands thrown in while busy and lone commands as noise.
  task automatic random_phase(input int n_ticks, input int hold_at);
    tick_in_t plan[$];
    tick_in_t t;
    int       n_bytes;
    bit       reading;
    for (int sent = 0; sent < n_ticks; sent++) begin
      t = filler(2);
      if (sb.busy()) begin
        if (sb.final_tick() && $urandom_range(0, 3) == 0)
          t.mode = 3'($urandom_range(MODE_START, MODE_READ));
        else if ($urandom_range(0, 24) == 0)
          t.mode = 3'($urandom_range(MODE_START, MODE_READ));
        else if ($urandom_range(0, 15) == 0)
          t.mode = 3'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
      end else if ($urandom_range(0, 3) != 0) begin
        if (plan.size() == 0) begin
          if ($urandom_range(0, 6) == 0) begin
            t.mode = 3'($urandom_range(MODE_START, MODE_READ));
            plan.push_back(t);
          end else begin
            reading = 1'($urandom);
            n_bytes = $urandom_range(1, 3);
            t.mode  = MODE_START;
            plan.push_back(t);
            t         = filler(2);
            t.mode    = MODE_WRITE;
            t.tx_byte = {7'($urandom), reading};
            plan.push_back(t);
            for (int i = 0; i < n_bytes; i++) begin
              t           = filler(2);
              t.mode      = reading ? MODE_READ : MODE_WRITE;
              t.last_byte = (i == n_bytes - 1);
              plan.push_back(t);
            end
            t      = filler(2);
            t.mode = MODE_STOP;
            plan.push_back(t);
          end
        end
        t = plan.pop_front();
      end else if ($urandom_range(0, 3) == 0) begin
        t.mode = 3'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
      end
      send_tick(t);
      if (sent == hold_at) hold_off_req = 1'b1;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request so the
  // result register backs up and the block stops taking ticks.
  initial begin
    int stall;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      stall = recv_calm ? 0 : pick_delay();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Check each result transaction and watch for a hung handshake
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_lines(out_o);
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    tick_in_t t;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Start and stop under the reset timing values
    run_op(MODE_START, 8'h00, 1'b0, 2);
    run_op(MODE_STOP, 8'h00, 1'b0, 2);

    // Shortest timing: plain and unknown mode codes while idle
    write_timing(8'd1, 8'd1, 8'd1);
    for (int m = MODE_TICK; m <= MODE_RSVD_LAST; m++) begin
      if (m >= MODE_START && m <= MODE_READ) continue;
      t      = filler(2);
      t.mode = 3'(m);
      send_tick(t);
    end
    // Stop on a bus that never saw a start
    run_op(MODE_STOP, 8'h00, 1'b0, 2);
    run_op(MODE_START, 8'h00, 1'b0, 2);
    run_op(MODE_WRITE, 8'h00, 1'b0, 2);
    run_op(MODE_WRITE, 8'hFF, 1'b0, 2);
    // All-low byte with ACK, then all-high byte with NACK
    run_op(MODE_READ, 8'h00, 1'b0, 0);
    run_op(MODE_READ, 8'h00, 1'b1, 1);

    // Command in the middle of a write, then one on its completing tick
    t         = filler(2);
    t.mode    = MODE_WRITE;
    t.tx_byte = 8'h3C;
    send_tick(t);
    send_tick(filler(2));
    t      = filler(2);
    t.mode = MODE_READ;
    send_tick(t);
    while (sb.busy() && !sb.final_tick()) send_tick(filler(2));
    t      = filler(2);
    t.mode = MODE_START;
    send_tick(t);
    run_op(MODE_STOP, 8'h00, 1'b0, 2);

    // Together with the two reads above, enough reads to wrap the ring
    repeat (RX_SLOTS - 1) run_op(MODE_READ, 8'($urandom), 1'($urandom), 2);

    // Zero registers behave as one tick
    write_timing(8'd0, 8'd0, 8'd0);
    run_op(MODE_START, 8'h00, 1'b0, 2);
    run_op(MODE_WRITE, 8'($urandom), 1'b0, 2);
    run_op(MODE_READ, 8'h00, 1'b0, 2);
    run_op(MODE_STOP, 8'h00, 1'b0, 2);

    // Random traffic under short random timings; one phase each with no
    // sender gaps, no receiver stalls, and the long receiver hold-off.
    for (int p = 0; p < 5; p++) begin
      send_calm = (p == 2);
      recv_calm = (p == 3);
      write_timing(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3)),
                   ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3)),
                   ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3)));
      random_phase(24, (p == 1) ? 8 : -1);
    end
    send_calm = 1'b0;
    recv_calm = 1'b0;
    settle();

    $display("covered %0d ticks over %0d timing settings: %0d start, %0d stop, %0d write, %0d read",
             sb.ticks, timing_sets, sb.begun[MODE_START], sb.begun[MODE_STOP],
             sb.begun[MODE_WRITE], sb.begun[MODE_READ]);
    $display("%0d commands dropped while busy, %0d bytes received, ring wrapped %0d times",
             sb.dropped, sb.bytes_in, sb.wraps);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/i2cbb_pkg.sv
rtl/i2c_bitbang_master.sv
test/tb_i2c_bitbang_master.sv
